@@ rtl/core/bfs_pkg.sv @@
// Shared constants, register codes and small helper functions for the boids step block.
// Depends on nothing; used by boids_flocking_step.
`timescale 1ns / 1ps

package bfs_pkg;

  // Default flock size bound and the world size in pixels with 8 fraction bits (Q11.8 in x, Q10.8 in y).
  localparam int MAX_BOIDS_DEF = 256;
  localparam int WORLD_W       = 409600;
  localparam int WORLD_H       = 230400;

  // Shared divider geometry: numerator and denominator widths.
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 38;

  // Configuration register reset values.
  localparam logic [9:0]  SEP_RADIUS_RST    = 10'd50;
  localparam logic [9:0]  ALIGN_RADIUS_RST  = 10'd70;
  localparam logic [9:0]  COHERE_RADIUS_RST = 10'd30;
  localparam logic [11:0] SEP_GAIN_RST      = 12'd384;
  localparam logic [11:0] ALIGN_GAIN_RST    = 12'd384;
  localparam logic [11:0] COHERE_GAIN_RST   = 12'd256;
  localparam logic [10:0] SPEED_CAP_RST     = 11'd768;
  localparam logic [10:0] FORCE_CAP_RST     = 11'd256;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SEP_RADIUS    = 3'd0,
    REG_ALIGN_RADIUS  = 3'd1,
    REG_COHERE_RADIUS = 3'd2,
    REG_SEP_GAIN      = 3'd3,
    REG_ALIGN_GAIN    = 3'd4,
    REG_COHERE_GAIN   = 3'd5,
    REG_SPEED_CAP     = 3'd6,
    REG_FORCE_CAP     = 3'd7
  } reg_idx_t;

  // Magnitude of a signed vector component; the most negative value wraps to zero.
  function automatic logic [31:0] mag32(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = v[32] ? -v : v;
    return t[31:0];
  endfunction

  // Saturate a 34-bit signed sum to 32-bit signed.
  function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 25-bit signed sum to 24-bit signed.
  function automatic logic signed [23:0] sat_s24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v > 25'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Clamp a velocity component to 12-bit signed.
  function automatic logic signed [11:0] sat_s12(input logic signed [32:0] v);
    logic signed [11:0] r;
    if (v > 33'sd2047) begin
      r = 12'sh7FF;
    end else if (v < -33'sd2048) begin
      r = 12'sh800;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/boids_flocking_step.sv @@
// Boids flocking step: neighbour accumulation and steering update for one boid.
// Depends on bfs_pkg; one shared multiplier, divider and square root under a sequencer.
`timescale 1ns / 1ps

// Channel        Signals                                   Direction
// command        start, busy, self_*, other_*, rule_enable, last    in (busy out)
// result         done, new_x, new_y, new_vx, new_vy        out
// configuration  wr_en, wr_index, wr_data                  in
//
// A neighbour item that falls inside the separation radius takes longer than one outside
// it: it needs the two 44-step divisions of the shared divider.
// The update on an item marked last uses the 32-step square root and the 44-step divider
// several times per steering rule.
// Reset is synchronous; it restores the register defaults and clears the sums.
// The result is shown for one cycle with done; the receiver cannot stall it.

module boids_flocking_step #(
  parameter int MAX_BOIDS = bfs_pkg::MAX_BOIDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [18:0]        self_x,
  input  logic [17:0]        self_y,
  input  logic signed [11:0] self_vx,
  input  logic signed [11:0] self_vy,
  input  logic [18:0]        other_x,
  input  logic [17:0]        other_y,
  input  logic signed [11:0] other_vx,
  input  logic signed [11:0] other_vy,
  input  logic [2:0]         rule_enable,
  input  logic               last,
  output logic               done,
  output logic [18:0]        new_x,
  output logic [17:0]        new_y,
  output logic signed [11:0] new_vx,
  output logic signed [11:0] new_vy,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [11:0]        wr_data
);

  localparam int NEIGH_CAP = ((MAX_BOIDS - 1) < 511) ? (MAX_BOIDS - 1) : 511;
  localparam logic [8:0] CAP9 = 9'(NEIGH_CAP);
  localparam int NW = bfs_pkg::DIV_NW;
  localparam int DW = bfs_pkg::DIV_DW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_MY, ST_MS, ST_SQ, ST_DIV, ST_D2, ST_RA, ST_RC, ST_RH,
    ST_SEPY, ST_SEPE, ST_NEXT, ST_RULE, ST_CDY, ST_CV, ST_SETLEN, ST_SLSQ,
    ST_NMX, ST_NDX, ST_NMY, ST_NDY, ST_NEND, ST_SUBV, ST_KCAP, ST_KCMP,
    ST_LIMDONE, ST_WX, ST_WY, ST_WE, ST_OUT
  } state_t;

  state_t state, ret;

  // Configuration registers.
  logic [9:0]  sep_radius, align_radius, cohere_radius;
  logic [11:0] sep_gain, align_gain, cohere_gain;
  logic [10:0] speed_cap, force_cap;

  // Neighbour sums.
  logic signed [31:0] sep_sum_x, sep_sum_y;
  logic signed [23:0] align_sum_x, align_sum_y;
  logic [31:0]        cohere_sum_x, cohere_sum_y;
  logic [8:0]         sep_count, align_count, cohere_count;

  // Captured item.
  logic [18:0]        sx_r, ox_r;
  logic [17:0]        sy_r, oy_r;
  logic signed [11:0] vx_r, vy_r, ovx_r, ovy_r;
  logic [2:0]         en_r;
  logic               last_r;
  logic signed [19:0] dx_r, dy_r;

  // Working vector, accumulators and control.
  logic signed [32:0] vec_x, vec_y;
  logic [31:0]        tmp_x;
  logic [63:0]        acc, p;
  logic [10:0]        scale;
  logic               mode;
  logic [1:0]         rule;
  logic signed [19:0] ax, ay;
  logic               sep_hit, aln_hit;
  logic [5:0]         iter;

  // Shared divider and square root registers.
  logic [NW-1:0] div_n;
  logic [DW-1:0] div_d, div_r;
  logic [63:0]   sq_rad;
  logic [34:0]   sq_rem;
  logic [31:0]   sq_root;

  logic [31:0] vax, vay, mul_a, mul_b;
  logic [11:0] gain_sel;

  assign busy = (state != ST_IDLE);
  assign vax  = bfs_pkg::mag32(vec_x);
  assign vay  = bfs_pkg::mag32(vec_y);

  always_comb begin
    case (rule)
      2'd0:    gain_sel = sep_gain;
      2'd1:    gain_sel = align_gain;
      default: gain_sel = cohere_gain;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MX: begin
        mul_a = vax;
        mul_b = vax;
      end
      ST_MY: begin
        mul_a = vay;
        mul_b = vay;
      end
      ST_D2: begin
        mul_a = {14'b0, sep_radius, 8'b0};
        mul_b = {14'b0, sep_radius, 8'b0};
      end
      ST_RA: begin
        mul_a = {14'b0, align_radius, 8'b0};
        mul_b = {14'b0, align_radius, 8'b0};
      end
      ST_RC: begin
        mul_a = {14'b0, cohere_radius, 8'b0};
        mul_b = {14'b0, cohere_radius, 8'b0};
      end
      ST_NMX: begin
        mul_a = vax;
        mul_b = {21'b0, scale};
      end
      ST_NMY: begin
        mul_a = vay;
        mul_b = {21'b0, scale};
      end
      ST_KCAP: begin
        mul_a = {21'b0, scale};
        mul_b = {21'b0, scale};
      end
      ST_WX: begin
        mul_a = vax;
        mul_b = {20'b0, gain_sel};
      end
      ST_WY: begin
        mul_a = vay;
        mul_b = {20'b0, gain_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One restoring divider step.
  logic [DW:0] div_sh, div_sub;
  logic        div_ge;
  assign div_sh  = {div_r, div_n[NW-1]};
  assign div_ge  = (div_sh >= {1'b0, div_d});
  assign div_sub = div_sh - {1'b0, div_d};

  // One digit step of the square root.
  logic [34:0] sq_sh, sq_trial, sq_sub;
  logic        sq_ge;
  assign sq_sh    = {sq_rem[32:0], sq_rad[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_sub   = sq_sh - sq_trial;

  // Saturating updates of the sums.
  logic signed [25:0] sep_q, sep_tx, sep_ty;
  logic signed [33:0] sep_nx, sep_ny;
  logic signed [24:0] aln_nx, aln_ny;
  logic [32:0]        coh_nx, coh_ny;
  logic [31:0]        dx_mag, dy_mag;
  assign dx_mag = bfs_pkg::mag32(33'(dx_r));
  assign dy_mag = bfs_pkg::mag32(33'(dy_r));
  assign sep_q  = {1'b0, div_n[24:0]};
  assign sep_tx = dx_r[19] ? -sep_q : sep_q;
  assign sep_ty = dy_r[19] ? -sep_q : sep_q;
  assign sep_nx = 34'(sep_sum_x) + 34'(sep_tx);
  assign sep_ny = 34'(sep_sum_y) + 34'(sep_ty);
  assign aln_nx = 25'(align_sum_x) + 25'(ovx_r);
  assign aln_ny = 25'(align_sum_y) + 25'(ovy_r);
  assign coh_nx = {1'b0, cohere_sum_x} + {14'b0, ox_r};
  assign coh_ny = {1'b0, cohere_sum_y} + {15'b0, oy_r};

  // Scaled component, weighted force and the final position.
  logic signed [32:0] quo_s;
  logic signed [16:0] wt;
  logic signed [11:0] nx_s, ny_s;
  logic signed [20:0] px, py, px_w, py_w;
  assign quo_s = {1'b0, div_n[31:0]};
  assign wt    = {1'b0, p[23:8]};
  assign nx_s  = bfs_pkg::sat_s12(vec_x);
  assign ny_s  = bfs_pkg::sat_s12(vec_y);
  assign px    = $signed({2'b0, sx_r}) + 21'(nx_s);
  assign py    = $signed({3'b0, sy_r}) + 21'(ny_s);

  always_comb begin
    if (px < 0) begin
      px_w = px + 21'(bfs_pkg::WORLD_W);
    end else if (px > 21'(bfs_pkg::WORLD_W)) begin
      px_w = px - 21'(bfs_pkg::WORLD_W);
    end else begin
      px_w = px;
    end
    if (py < 0) begin
      py_w = py + 21'(bfs_pkg::WORLD_H);
    end else if (py > 21'(bfs_pkg::WORLD_H)) begin
      py_w = py - 21'(bfs_pkg::WORLD_H);
    end else begin
      py_w = py;
    end
  end

  // The product is registered every cycle; each state uses it in the cycle after its operands were selected.
  always_ff @(posedge clk) begin
    p <= 64'(mul_a) * 64'(mul_b);
  end

  // Sequencer, sums, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret           <= ST_IDLE;
      done          <= 1'b0;
      sep_radius    <= bfs_pkg::SEP_RADIUS_RST;
      align_radius  <= bfs_pkg::ALIGN_RADIUS_RST;
      cohere_radius <= bfs_pkg::COHERE_RADIUS_RST;
      sep_gain      <= bfs_pkg::SEP_GAIN_RST;
      align_gain    <= bfs_pkg::ALIGN_GAIN_RST;
      cohere_gain   <= bfs_pkg::COHERE_GAIN_RST;
      speed_cap     <= bfs_pkg::SPEED_CAP_RST;
      force_cap     <= bfs_pkg::FORCE_CAP_RST;
      sep_sum_x     <= '0;
      sep_sum_y     <= '0;
      align_sum_x   <= '0;
      align_sum_y   <= '0;
      cohere_sum_x  <= '0;
      cohere_sum_y  <= '0;
      sep_count     <= '0;
      align_count   <= '0;
      cohere_count  <= '0;
    end else begin
      done <= 1'b0;

      // Configuration writes.
      if (wr_en) begin
        case (bfs_pkg::reg_idx_t'(wr_index))
          bfs_pkg::REG_SEP_RADIUS:    sep_radius    <= wr_data[9:0];
          bfs_pkg::REG_ALIGN_RADIUS:  align_radius  <= wr_data[9:0];
          bfs_pkg::REG_COHERE_RADIUS: cohere_radius <= wr_data[9:0];
          bfs_pkg::REG_SEP_GAIN:      sep_gain      <= wr_data;
          bfs_pkg::REG_ALIGN_GAIN:    align_gain    <= wr_data;
          bfs_pkg::REG_COHERE_GAIN:   cohere_gain   <= wr_data;
          bfs_pkg::REG_SPEED_CAP:     speed_cap     <= wr_data[10:0];
          bfs_pkg::REG_FORCE_CAP:     force_cap     <= wr_data[10:0];
          default: ;
        endcase
      end

      case (state)
        // Capture the transfer and measure the squared distance.
        ST_IDLE: begin
          if (start) begin
            sx_r   <= self_x;
            sy_r   <= self_y;
            vx_r   <= self_vx;
            vy_r   <= self_vy;
            ox_r   <= other_x;
            oy_r   <= other_y;
            ovx_r  <= other_vx;
            ovy_r  <= other_vy;
            en_r   <= rule_enable;
            last_r <= last;
            dx_r   <= $signed({1'b0, self_x}) - $signed({1'b0, other_x});
            dy_r   <= $signed({2'b0, self_y}) - $signed({2'b0, other_y});
            vec_x  <= $signed({14'b0, self_x}) - $signed({14'b0, other_x});
            vec_y  <= $signed({15'b0, self_y}) - $signed({15'b0, other_y});
            ret    <= ST_D2;
            state  <= ST_MX;
          end
        end

        // Squared magnitude of the working vector into acc.
        ST_MX: state <= ST_MY;
        ST_MY: begin
          acc   <= p;
          state <= ST_MS;
        end
        ST_MS: begin
          acc   <= acc + p;
          state <= ret;
        end

        // Square root iterations: sq_root ends as floor(sqrt(acc)).
        ST_SQ: begin
          sq_rem  <= sq_ge ? sq_sub : sq_sh;
          sq_root <= {sq_root[30:0], sq_ge};
          sq_rad  <= {sq_rad[61:0], 2'b00};
          iter    <= iter + 6'd1;
          if (iter == 6'd31) begin
            state <= ret;
          end
        end

        // Divider iterations: div_n ends as the quotient.
        ST_DIV: begin
          div_r <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
          div_n <= {div_n[NW-2:0], div_ge};
          iter  <= iter + 6'd1;
          if (iter == 6'(NW - 1)) begin
            state <= ret;
          end
        end

        // Radius tests, one squared radius per cycle.
        ST_D2: state <= ST_RA;
        ST_RA: begin
          sep_hit <= (acc != 64'd0) && (acc < p) && (sep_count < CAP9);
          state   <= ST_RC;
        end
        ST_RC: begin
          aln_hit <= (acc != 64'd0) && (acc < p) && (align_count < CAP9);
          state   <= ST_RH;
        end
        ST_RH: begin
          if (aln_hit) begin
            align_sum_x <= bfs_pkg::sat_s24(aln_nx);
            align_sum_y <= bfs_pkg::sat_s24(aln_ny);
            align_count <= align_count + 9'd1;
          end
          if ((acc != 64'd0) && (acc < p) && (cohere_count < CAP9)) begin
            cohere_sum_x <= coh_nx[32] ? 32'hFFFFFFFF : coh_nx[31:0];
            cohere_sum_y <= coh_ny[32] ? 32'hFFFFFFFF : coh_ny[31:0];
            cohere_count <= cohere_count + 9'd1;
          end
          if (sep_hit) begin
            div_n <= {dx_mag[19:0], 24'b0};
            div_d <= acc[DW-1:0];
            div_r <= '0;
            iter  <= '0;
            ret   <= ST_SEPY;
            state <= ST_DIV;
          end else begin
            state <= ST_NEXT;
          end
        end

        // Separation term, x then y.
        ST_SEPY: begin
          sep_sum_x <= bfs_pkg::sat_s32(sep_nx);
          div_n     <= {dy_mag[19:0], 24'b0};
          div_r     <= '0;
          iter      <= '0;
          ret       <= ST_SEPE;
          state     <= ST_DIV;
        end
        ST_SEPE: begin
          sep_sum_y <= bfs_pkg::sat_s32(sep_ny);
          sep_count <= sep_count + 9'd1;
          state     <= ST_NEXT;
        end

        ST_NEXT: begin
          if (last_r) begin
            ax    <= '0;
            ay    <= '0;
            rule  <= 2'd0;
            state <= ST_RULE;
          end else begin
            state <= ST_IDLE;
          end
        end

        // Pick the next steering rule, or the final speed limit.
        ST_RULE: begin
          case (rule)
            2'd0: begin
              if (en_r[0] && ((sep_sum_x != 0) || (sep_sum_y != 0))) begin
                vec_x <= 33'(sep_sum_x);
                vec_y <= 33'(sep_sum_y);
                state <= ST_SETLEN;
              end else begin
                rule <= 2'd1;
              end
            end
            2'd1: begin
              if (en_r[1] && (align_count != 9'd0)) begin
                vec_x <= 33'(align_sum_x);
                vec_y <= 33'(align_sum_y);
                state <= ST_SETLEN;
              end else begin
                rule <= 2'd2;
              end
            end
            2'd2: begin
              if (en_r[2] && (cohere_count != 9'd0)) begin
                div_n <= {12'b0, cohere_sum_x};
                div_d <= {29'b0, cohere_count};
                div_r <= '0;
                iter  <= '0;
                ret   <= ST_CDY;
                state <= ST_DIV;
              end else begin
                rule <= 2'd3;
              end
            end
            default: begin
              vec_x <= 33'(vx_r) + 33'(ax);
              vec_y <= 33'(vy_r) + 33'(ay);
              mode  <= 1'b1;
              scale <= speed_cap;
              ret   <= ST_KCAP;
              state <= ST_MX;
            end
          endcase
        end

        // Cohesion target is the mean position; steer toward it.
        ST_CDY: begin
          tmp_x <= div_n[31:0];
          div_n <= {12'b0, cohere_sum_y};
          div_r <= '0;
          iter  <= '0;
          ret   <= ST_CV;
          state <= ST_DIV;
        end
        ST_CV: begin
          vec_x <= $signed({1'b0, tmp_x}) - $signed({14'b0, sx_r});
          vec_y <= $signed({1'b0, div_n[31:0]}) - $signed({15'b0, sy_r});
          state <= ST_SETLEN;
        end

        // Scale the vector to speed_cap; a zero vector stays zero.
        ST_SETLEN: begin
          if ((vec_x == 0) && (vec_y == 0)) begin
            state <= ST_SUBV;
          end else begin
            mode  <= 1'b0;
            scale <= speed_cap;
            ret   <= ST_SLSQ;
            state <= ST_MX;
          end
        end
        ST_SLSQ: begin
          sq_rad  <= acc;
          sq_rem  <= '0;
          sq_root <= '0;
          iter    <= '0;
          ret     <= ST_NMX;
          state   <= ST_SQ;
        end

        // Shared tail: component times scale over the magnitude.
        ST_NMX: state <= ST_NDX;
        ST_NDX: begin
          div_n <= p[NW-1:0];
          div_d <= {6'b0, sq_root};
          div_r <= '0;
          iter  <= '0;
          ret   <= ST_NMY;
          state <= ST_DIV;
        end
        ST_NMY: begin
          vec_x <= vec_x[32] ? -quo_s : quo_s;
          state <= ST_NDY;
        end
        ST_NDY: begin
          div_n <= p[NW-1:0];
          div_r <= '0;
          iter  <= '0;
          ret   <= ST_NEND;
          state <= ST_DIV;
        end
        ST_NEND: begin
          vec_y <= vec_y[32] ? -quo_s : quo_s;
          state <= mode ? ST_LIMDONE : ST_SUBV;
        end

        // Steering force is desired minus velocity, limited to force_cap.
        ST_SUBV: begin
          vec_x <= vec_x - 33'(vx_r);
          vec_y <= vec_y - 33'(vy_r);
          mode  <= 1'b1;
          scale <= force_cap;
          ret   <= ST_KCAP;
          state <= ST_MX;
        end
        ST_KCAP: state <= ST_KCMP;
        ST_KCMP: begin
          if (acc > p) begin
            sq_rad  <= acc;
            sq_rem  <= '0;
            sq_root <= '0;
            iter    <= '0;
            ret     <= ST_NMX;
            state   <= ST_SQ;
          end else begin
            state <= ST_LIMDONE;
          end
        end
        ST_LIMDONE: state <= (rule == 2'd3) ? ST_OUT : ST_WX;

        // Weight the force and add it to the acceleration.
        ST_WX: state <= ST_WY;
        ST_WY: begin
          ax    <= ax + (vec_x[32] ? -20'(wt) : 20'(wt));
          state <= ST_WE;
        end
        ST_WE: begin
          ay    <= ay + (vec_y[32] ? -20'(wt) : 20'(wt));
          rule  <= rule + 2'd1;
          state <= ST_RULE;
        end

        // Deliver the result and clear the sums.
        ST_OUT: begin
          new_vx       <= nx_s;
          new_vy       <= ny_s;
          new_x        <= px_w[18:0];
          new_y        <= py_w[17:0];
          done         <= 1'b1;
          sep_sum_x    <= '0;
          sep_sum_y    <= '0;
          align_sum_x  <= '0;
          align_sum_y  <= '0;
          cohere_sum_x <= '0;
          cohere_sum_y <= '0;
          sep_count    <= '0;
          align_count  <= '0;
          cohere_count <= '0;
          state        <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result only ever closes a busy stretch.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without preceding work");

  // An accepted transfer always makes the block busy.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

  // Neighbour counts never pass their cap.
  assert property (@(posedge clk) disable iff (rst)
      (sep_count <= CAP9) && (align_count <= CAP9) && (cohere_count <= CAP9))
    else $error("neighbour count above cap");

  // The sums are empty right after a result.
  assert property (@(posedge clk) disable iff (rst)
      done |-> ((sep_count == 9'd0) && (align_count == 9'd0) && (cohere_count == 9'd0)))
    else $error("sums not cleared after result");
`endif

endmodule
